FILE: rtl/core/bms_pkg.sv
// Shared types and constants of the bump map shader.
`timescale 1ns / 1ps
`default_nettype none

package bms_pkg;

    // Request codes
    localparam logic FUNC_TABLE_WRITE = 1'b0;
    localparam logic FUNC_PIXEL       = 1'b1;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_LIGHT_X      = 2'd2,
        REG_LIGHT_Y      = 2'd3
    } reg_index_t;

    localparam int CFG_DIM_W    = 11;
    localparam int CFG_LIGHT_W  = 12;
    localparam int DIM_MIN      = 2;
    localparam int LIGHT_CENTER = 128;
    localparam int TABLE_SIDE   = 256;
    localparam int TABLE_DEPTH  = TABLE_SIDE * TABLE_SIDE;
    localparam int TABLE_AW     = $clog2(TABLE_DEPTH);

    localparam logic [CFG_DIM_W-1:0]   WIDTH_RESET  = 11'd320;
    localparam logic [CFG_DIM_W-1:0]   HEIGHT_RESET = 11'd200;

    typedef struct packed {
        logic        func;
        logic [15:0] table_index;
        logic [7:0]  table_value;
        logic [7:0]  height;
    } req_t;

    typedef struct packed {
        logic [7:0] shade;
        logic [9:0] out_row;
        logic [9:0] out_col;
        logic       last_of_run;
        logic       frame_done;
    } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/bump_map_shader.sv
// Bump map shader top level: line buffer, light table lookup and result expansion.
`timescale 1ns / 1ps
`default_nettype none

// Height pixels arrive in raster order, one per clock at most; a request with
// func 0 writes one light table entry instead. Each pixel reads and rewrites
// the row buffer entry of its column at the accepting edge, the light table
// is looked up as the pixel moves from stage 1 into stage 2, which waits
// until the output is free. A pixel emits the result for the pixel above
// and to its left, so row 0 and column 0 emit nothing; the last column and
// the last row add repeated results, up to four per pixel. Results leave at
// one per cycle while rsp_ready is high, through a single output register.
// A pixel in the last column or the last row keeps that register for two
// results, four at the bottom right corner; a pixel in the last row before
// the last column therefore holds back the next pixel in stage 1 while its
// second result leaves, and every other request moves on without such a
// hold while the result side keeps up. Writing image_width or image_height
// restarts the frame. Configure only while idle.
module bump_map_shader #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               req_valid,
    output logic              req_ready,
    input  wire bms_pkg::req_t req,
    output logic              rsp_valid,
    input  wire               rsp_ready,
    output bms_pkg::rsp_t     rsp,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [3:0]        paddr,
    input  wire  [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bms_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int DW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int MW = (CW > RW) ? CW : RW;
    localparam int SW = ((MW > CFG_LIGHT_W) ? MW : CFG_LIGHT_W) + 3;

    // Configuration registers
    logic [CFG_DIM_W-1:0]          image_width_reg;
    logic [CFG_DIM_W-1:0]          image_height_reg;
    logic signed [CFG_LIGHT_W-1:0] light_x_reg;
    logic signed [CFG_LIGHT_W-1:0] light_y_reg;

    logic       cfg_write;
    reg_index_t cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RESET;
            image_height_reg <= HEIGHT_RESET;
            light_x_reg      <= '0;
            light_y_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[CFG_DIM_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[CFG_DIM_W-1:0];
                REG_LIGHT_X:      light_x_reg      <= signed'(pwdata[CFG_LIGHT_W-1:0]);
                REG_LIGHT_Y:      light_y_reg      <= signed'(pwdata[CFG_LIGHT_W-1:0]);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_IMAGE_WIDTH:  prdata = 32'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(image_height_reg);
            REG_LIGHT_X:      prdata = 32'(unsigned'(light_x_reg));
            REG_LIGHT_Y:      prdata = 32'(unsigned'(light_y_reg));
            default:          prdata = '0;
        endcase
    end

    // Frame dimensions clamped to the supported range
    logic [DW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;

    always_comb
    begin
        if (32'(image_width_reg) < 32'(DIM_MIN))
            w_clamp = DW'(DIM_MIN);
        else if (32'(image_width_reg) > 32'(MAX_WIDTH))
            w_clamp = DW'(MAX_WIDTH);
        else
            w_clamp = DW'(image_width_reg);

        if (32'(image_height_reg) < 32'(DIM_MIN))
            h_clamp = HW'(DIM_MIN);
        else if (32'(image_height_reg) > 32'(MAX_HEIGHT))
            h_clamp = HW'(MAX_HEIGHT);
        else
            h_clamp = HW'(image_height_reg);

        wm1 = CW'(w_clamp - DW'(1));
        hm1 = RW'(h_clamp - HW'(1));
    end

    // Pipeline handshake
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s1_emit;
    logic s1_go;
    logic s2_free;
    logic s2_last;
    logic accept;
    logic accept_pixel;

    assign accept       = req_valid && req_ready;
    assign accept_pixel = accept && (req.func == FUNC_PIXEL);

    // Raster position of the incoming pixel
    logic [CW-1:0] col_reg, col_next, col_cur;
    logic [RW-1:0] row_reg, row_next, row_cur;

    always_comb
    begin
        col_cur  = (DW'(col_reg) >= w_clamp) ? '0 : col_reg;
        row_cur  = (HW'(row_reg) >= h_clamp) ? '0 : row_reg;
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_write && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept_pixel)
        begin
            if (DW'(col_cur) + DW'(1) >= w_clamp)
            begin
                col_next = '0;
                row_next = (HW'(row_cur) + HW'(1) >= h_clamp) ? '0 : RW'(row_cur + RW'(1));
            end
            else
            begin
                col_next = CW'(col_cur + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Row buffer: read the entry above, then overwrite it with this pixel
    logic [7:0] row_mem [MAX_WIDTH];
    logic [7:0] up_rd_reg;

    always_ff @(posedge clk)
    begin
        if (accept_pixel)
        begin
            up_rd_reg        <= row_mem[col_cur];
            row_mem[col_cur] <= req.height;
        end
    end

    // Stage 1: request with its raster position, row buffer data arriving
    logic          s1_func_reg;
    logic [15:0]   s1_index_reg;
    logic [7:0]    s1_value_reg;
    logic [7:0]    s1_pix_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg  <= req.func;
            s1_index_reg <= req.table_index;
            s1_value_reg <= req.table_value;
            s1_pix_reg   <= req.height;
            s1_col_reg   <= col_cur;
            s1_row_reg   <= row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_go)
            s1_valid_reg <= 1'b0;
    end

    // Left neighbors of the pixel in stage 1
    logic [7:0] above_left_reg;
    logic [7:0] current_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_left_reg   <= '0;
            current_left_reg <= '0;
        end
        else if (s1_go && s1_func_reg == FUNC_PIXEL)
        begin
            above_left_reg   <= up_rd_reg;
            current_left_reg <= s1_pix_reg;
        end
    end

    // Light table coordinates
    logic signed [SW-1:0] dx, dy, xs, ys;
    logic [7:0]           x_clamp, y_clamp;
    logic [TABLE_AW-1:0]  light_addr;

    always_comb
    begin
        dx = SW'(signed'({1'b0, up_rd_reg})) - SW'(signed'({1'b0, above_left_reg}));
        dy = SW'(signed'({1'b0, current_left_reg})) - SW'(signed'({1'b0, above_left_reg}));
        xs = dx + SW'(light_x_reg) + SW'(LIGHT_CENTER + 1)
           - SW'(signed'({1'b0, s1_col_reg}));
        ys = dy + SW'(light_y_reg) + SW'(LIGHT_CENTER + 1)
           - SW'(signed'({1'b0, s1_row_reg}));

        if (xs < 0)
            x_clamp = 8'd0;
        else if (xs > SW'(TABLE_SIDE - 1))
            x_clamp = 8'(TABLE_SIDE - 1);
        else
            x_clamp = xs[7:0];

        if (ys < 0)
            y_clamp = 8'd0;
        else if (ys > SW'(TABLE_SIDE - 1))
            y_clamp = 8'(TABLE_SIDE - 1);
        else
            y_clamp = ys[7:0];

        light_addr = {y_clamp, x_clamp};
    end

    assign s1_emit   = (s1_func_reg == FUNC_PIXEL) && (s1_col_reg != '0) && (s1_row_reg != '0);
    assign s1_go     = s1_valid_reg && (!s1_emit || s2_free);
    assign req_ready = !s1_valid_reg || s1_go;

    // Light table: writes and lookups stay in request order
    logic [7:0] light_mem [TABLE_DEPTH];
    logic [7:0] shade_rd_reg;

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            if (s1_func_reg == FUNC_TABLE_WRITE)
                light_mem[s1_index_reg[TABLE_AW-1:0]] <= s1_value_reg;
            else if (s1_emit)
                shade_rd_reg <= light_mem[light_addr];
        end
    end

    // Stage 2: expand one pixel into its results
    logic [CW-1:0] s2_col_reg;
    logic [RW-1:0] s2_row_reg;
    logic [CW-1:0] s2_wm1_reg;
    logic          s2_last_col_reg;
    logic          s2_last_row_reg;
    logic [1:0]    step_reg, step_next;

    always_comb
    begin
        s2_last   = 1'b0;
        step_next = step_reg;
        if (s2_last_col_reg && !step_reg[0])
            step_next = step_reg | 2'b01;
        else if (s2_last_row_reg && !step_reg[1])
            step_next = 2'b10;
        else
            s2_last = 1'b1;
    end

    assign s2_free = !s2_valid_reg || (rsp_ready && s2_last);

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit)
        begin
            s2_col_reg      <= CW'(s1_col_reg - CW'(1));
            s2_row_reg      <= RW'(s1_row_reg - RW'(1));
            s2_wm1_reg      <= wm1;
            s2_last_col_reg <= (s1_col_reg == wm1);
            s2_last_row_reg <= (s1_row_reg == hm1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            step_reg     <= '0;
        end
        else if (s1_go && s1_emit)
        begin
            s2_valid_reg <= 1'b1;
            step_reg     <= '0;
        end
        else if (s2_valid_reg && rsp_ready)
        begin
            if (s2_last)
                s2_valid_reg <= 1'b0;
            else
                step_reg <= step_next;
        end
    end

    assign rsp_valid = s2_valid_reg;

    always_comb
    begin
        rsp.shade       = shade_rd_reg;
        rsp.out_row     = 10'(s2_row_reg + RW'(step_reg[1]));
        rsp.out_col     = 10'(step_reg[0] ? s2_wm1_reg : s2_col_reg);
        rsp.last_of_run = s2_last;
        rsp.frame_done  = step_reg[1] && step_reg[0];
    end

endmodule

`default_nettype wire
